/* hw/rtl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
`timescale 1ns / 1ps
package salc_pkg;

  // Outcome codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_CLEAN = 2'd1;
  localparam logic [1:0] OUT_DIRTY = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] REG_BLK_LOG2     = 8'd0;
  localparam logic [7:0] REG_SET_LOG2     = 8'd1;
  localparam logic [7:0] REG_WAYS_IN_USE  = 8'd2;
  localparam logic [7:0] REG_MISS_PENALTY = 8'd3;

  // Configuration reset values
  localparam logic [4:0] RST_BLK_LOG2     = 5'd4;
  localparam logic [3:0] RST_SET_LOG2     = 4'd6;
  localparam logic [3:0] RST_WAYS_IN_USE  = 4'd4;
  localparam logic [9:0] RST_MISS_PENALTY = 10'd100;

  // Field limits
  localparam logic [4:0] MAX_BLK_LOG2 = 5'd16;
  localparam logic [3:0] MAX_SET_LOG2 = 4'd8;
  localparam logic [31:0] TAG_RESET   = 32'hffff_ffff;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_WRITE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take input item, read the set row
    logic compute;  // lookup, victim choice, build new row and result
    logic commit;   // write row back, load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full; // output register holds a result not taken this cycle
  } status_t;

endpackage

/* hw/rtl/salc_if.sv */
// Channel interfaces: access requests, results and configuration writes.
`timescale 1ns / 1ps
interface salc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] address;
  logic [31:0] access_number;
  modport source(output valid, operation, address, access_number, input ready);
  modport sink(input valid, operation, address, access_number, output ready);
endinterface

interface salc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [7:0]  set_index;
  logic [31:0] tag;
  logic [2:0]  way;
  logic [31:0] old_tag;
  logic        old_valid;
  logic        old_dirty;
  logic [31:0] old_last_used;
  logic [10:0] cost;
  logic [17:0] bytes_moved;
  modport source(output valid, outcome, set_index, tag, way, old_tag, old_valid,
                 old_dirty, old_last_used, cost, bytes_moved, input ready);
  modport sink(input valid, outcome, set_index, tag, way, old_tag, old_valid,
               old_dirty, old_last_used, cost, bytes_moved, output ready);
endinterface

interface salc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/salc_ctrl.sv */
// Controller state machine: sequences read, lookup and write-back of one access.
`timescale 1ns / 1ps
module salc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  salc_pkg::status_t status,
  output salc_pkg::cmd_t    cmd
);

  salc_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      salc_pkg::S_IDLE: begin
        if (in_valid) state_next = salc_pkg::S_LOOK;
      end
      salc_pkg::S_LOOK: begin
        state_next = salc_pkg::S_WRITE;
      end
      salc_pkg::S_WRITE: begin
        if (!status.out_full) state_next = salc_pkg::S_IDLE;
      end
      default: state_next = salc_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      salc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      salc_pkg::S_LOOK: begin
        cmd.compute = 1'b1;
      end
      salc_pkg::S_WRITE: begin
        cmd.commit = !status.out_full;
      end
      default: ;
    endcase
  end

  // A lookup always follows a capture, and a commit never comes straight from idle
  a_capture_then_compute: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.compute)
    else $error("capture not followed by lookup");
  a_compute_then_write: assert property (@(posedge clk) disable iff (rst)
    cmd.compute |=> state == salc_pkg::S_WRITE)
    else $error("lookup not followed by write state");
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != salc_pkg::S_IDLE) |-> !cmd.capture)
    else $error("capture while access in flight");

endmodule

/* hw/rtl/salc_dpath.sv */
// Datapath: configuration, set row memory, tag compare, LRU update and result register.
`timescale 1ns / 1ps
module salc_dpath #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  salc_pkg::cmd_t    cmd,
  output salc_pkg::status_t status,
  input  logic              in_operation,
  input  logic [31:0]       in_address,
  input  logic [31:0]       in_access_number,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_outcome,
  output logic [7:0]        out_set_index,
  output logic [31:0]       out_tag,
  output logic [2:0]        out_way,
  output logic [31:0]       out_old_tag,
  output logic              out_old_valid,
  output logic              out_old_dirty,
  output logic [31:0]       out_old_last_used,
  output logic [10:0]       out_cost,
  output logic [17:0]       out_bytes_moved
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W = WAY_W;
  localparam int WC_W  = $clog2(MAX_WAYS + 1);

  typedef struct packed {
    logic [MAX_WAYS-1:0][31:0]      tags;
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][31:0]      last;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [WC_W-1:0]                fill;
  } row_t;

  // Configuration registers
  logic [4:0] blk_log2;
  logic [3:0] set_log2;
  logic [3:0] ways_in_use;
  logic [9:0] miss_penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_log2     <= salc_pkg::RST_BLK_LOG2;
      set_log2     <= salc_pkg::RST_SET_LOG2;
      ways_in_use  <= salc_pkg::RST_WAYS_IN_USE;
      miss_penalty <= salc_pkg::RST_MISS_PENALTY;
    end else if (cfg_valid) begin
      case (cfg_index)
        salc_pkg::REG_BLK_LOG2:     blk_log2     <= cfg_data[4:0];
        salc_pkg::REG_SET_LOG2:     set_log2     <= cfg_data[3:0];
        salc_pkg::REG_WAYS_IN_USE:  ways_in_use  <= cfg_data[3:0];
        salc_pkg::REG_MISS_PENALTY: miss_penalty <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry
  logic [4:0]      ob;
  logic [3:0]      ib;
  logic [5:0]      tag_sh;
  logic [4:0]      ways_x;
  logic [4:0]      e_full;
  logic [WC_W-1:0] e;

  assign ob     = (blk_log2 > salc_pkg::MAX_BLK_LOG2) ? salc_pkg::MAX_BLK_LOG2
                                                      : blk_log2;
  assign ib     = (set_log2 > salc_pkg::MAX_SET_LOG2) ? salc_pkg::MAX_SET_LOG2
                                                      : set_log2;
  assign tag_sh = 6'(ob) + 6'(ib);
  assign ways_x = {1'b0, ways_in_use};

  always_comb begin
    if (ways_x == 5'd0)               e_full = 5'd1;
    else if (ways_x > 5'(MAX_WAYS))   e_full = 5'(MAX_WAYS);
    else                              e_full = ways_x;
  end
  assign e = WC_W'(e_full);

  // Set number folded into the sets present
  logic [SET_W-1:0] mod_tab [256];
  for (genvar k = 0; k < 256; k++) begin : g_mod
    assign mod_tab[k] = SET_W'(k % MAX_SETS);
  end

  logic [31:0]      set_mask;
  logic [7:0]       set_raw;
  logic [SET_W-1:0] in_set;
  logic [31:0]      in_tag;

  assign set_mask = (32'd1 << ib) - 32'd1;
  assign set_raw  = 8'((in_address >> ob) & set_mask);
  assign in_set   = mod_tab[set_raw];
  assign in_tag   = in_address >> tag_sh;

  // Captured access
  logic             cur_write;
  logic [SET_W-1:0] cur_set;
  logic [31:0]      cur_tag;
  logic [31:0]      cur_num;
  logic [4:0]       cur_ob;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_write <= in_operation;
      cur_set   <= in_set;
      cur_tag   <= in_tag;
      cur_num   <= in_access_number;
      cur_ob    <= ob;
    end
  end

  // Set row memory, one row of all ways per set
  row_t              mem [MAX_SETS];
  row_t              rd_row;
  row_t              new_row;
  logic              rd_ok;
  logic [MAX_SETS-1:0] row_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) rd_row <= mem[in_set];
    if (cmd.commit)  mem[cur_set] <= new_row;
  end

  // Row written marks; an unwritten row reads as the reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (cmd.commit) begin
      row_ok[cur_set] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rd_ok <= row_ok[in_set];
  end

  row_t rst_row;
  always_comb begin
    rst_row = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      rst_row.tags[i] = salc_pkg::TAG_RESET;
      rst_row.age[i]  = AGE_W'(i);
    end
  end

  row_t row;
  assign row = rd_ok ? rd_row : rst_row;

  // Lookup and victim choice
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] lru_way;
  logic [AGE_W:0]   best_age;
  logic             fill_open;
  logic [WAY_W-1:0] w;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    lru_way  = '0;
    best_age = '1;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WC_W'(i) < e) begin
        if (!hit && row.valid[i] && row.tags[i] == cur_tag) begin
          hit     = 1'b1;
          hit_way = WAY_W'(i);
        end
        if ({1'b0, row.age[i]} < best_age) begin
          best_age = {1'b0, row.age[i]};
          lru_way  = WAY_W'(i);
        end
      end
    end
  end

  assign fill_open = row.fill < e;
  assign w = hit ? hit_way : (fill_open ? WAY_W'(row.fill) : lru_way);

  // Updated row
  logic [AGE_W-1:0] old_age;
  assign old_age = row.age[w];

  row_t upd_row;
  always_comb begin
    upd_row = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WC_W'(i) < e && WAY_W'(i) != w && row.age[i] > old_age) begin
        upd_row.age[i] = row.age[i] - AGE_W'(1);
      end
    end
    upd_row.age[w]  = AGE_W'(e - WC_W'(1));
    upd_row.last[w] = cur_num;
    if (hit) begin
      if (cur_write) upd_row.dirty[w] = 1'b1;
    end else begin
      upd_row.tags[w]  = cur_tag;
      upd_row.valid[w] = 1'b1;
      upd_row.dirty[w] = cur_write;
      if (fill_open) upd_row.fill = row.fill + WC_W'(1);
    end
  end

  // Outcome, cost and traffic
  logic        dirty_victim;
  logic [17:0] block;
  logic [1:0]  res_outcome;
  logic [10:0] res_cost;
  logic [17:0] res_bytes;

  assign dirty_victim = row.valid[w] && row.dirty[w];
  assign block        = 18'd1 << cur_ob;

  always_comb begin
    if (hit) begin
      res_outcome = salc_pkg::OUT_HIT;
      res_cost    = 11'd1;
      res_bytes   = 18'd0;
    end else if (dirty_victim) begin
      res_outcome = salc_pkg::OUT_DIRTY;
      res_cost    = 11'd1 + {miss_penalty, 1'b0};
      res_bytes   = block << 1;
    end else begin
      res_outcome = salc_pkg::OUT_CLEAN;
      res_cost    = 11'd1 + 11'(miss_penalty);
      res_bytes   = block;
    end
  end

  // Result staging between lookup and commit
  logic [1:0]  st_outcome;
  logic [2:0]  st_way;
  logic [31:0] st_old_tag;
  logic        st_old_valid;
  logic        st_old_dirty;
  logic [31:0] st_old_last;
  logic [10:0] st_cost;
  logic [17:0] st_bytes;

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      new_row      <= upd_row;
      st_outcome   <= res_outcome;
      st_way       <= 3'(w);
      st_old_tag   <= row.tags[w];
      st_old_valid <= row.valid[w];
      st_old_dirty <= row.dirty[w];
      st_old_last  <= row.last[w];
      st_cost      <= res_cost;
      st_bytes     <= res_bytes;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome       <= st_outcome;
      out_set_index     <= 8'(cur_set);
      out_tag           <= cur_tag;
      out_way           <= st_way;
      out_old_tag       <= st_old_tag;
      out_old_valid     <= st_old_valid;
      out_old_dirty     <= st_old_dirty;
      out_old_last_used <= st_old_last;
      out_cost          <= st_cost;
      out_bytes_moved   <= st_bytes;
    end
  end

  assign status.out_full = out_valid && !out_ready;

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not shown");
  a_hit_cost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_outcome == salc_pkg::OUT_HIT) |-> (out_cost == 11'd1 &&
    out_bytes_moved == 18'd0))
    else $error("hit charged for traffic");
  a_way_in_use: assert property (@(posedge clk) disable iff (rst)
    cmd.compute |-> (WC_W'(w) < e))
    else $error("way beyond associativity");
  a_no_commit_over_full: assert property (@(posedge clk) disable iff (rst)
    status.out_full |-> !cmd.commit)
    else $error("result overwritten");

endmodule

/* hw/rtl/set_associative_lru_cache_model.sv */
// Top level: set-associative, true-LRU, write-back cache model.
// A result is shown when its access ends the lookup and write-back states.
// One access at a time in three steps (set row read, lookup, row write-back);
//   the write-back waits while a finished result is not taken.
// Reset clears control state, config to 4/6/4/100; sets read as empty until
//   first written, through one written mark per set (no clearing pass).
`timescale 1ns / 1ps
module set_associative_lru_cache_model #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input logic        clk,
  input logic        rst,
  salc_req_if.sink   req,
  salc_rsp_if.source rsp,
  salc_cfg_if.sink   cfg
);

  salc_pkg::cmd_t    cmd;
  salc_pkg::status_t status;
  logic              in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  salc_dpath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_operation      (req.operation),
    .in_address        (req.address),
    .in_access_number  (req.access_number),
    .cfg_valid         (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .out_ready         (rsp.ready),
    .out_valid         (rsp.valid),
    .out_outcome       (rsp.outcome),
    .out_set_index     (rsp.set_index),
    .out_tag           (rsp.tag),
    .out_way           (rsp.way),
    .out_old_tag       (rsp.old_tag),
    .out_old_valid     (rsp.old_valid),
    .out_old_dirty     (rsp.old_dirty),
    .out_old_last_used (rsp.old_last_used),
    .out_cost          (rsp.cost),
    .out_bytes_moved   (rsp.bytes_moved)
  );

endmodule
